FILE: rtl/core/rmnh_pkg.sv
`timescale 1ns / 1ps
package rmnh_pkg;

  // Coordinate field width and packed register width.
  localparam int CW     = 21;
  localparam int REG_W  = 3 * CW;
  localparam int VW     = CW + 1;        // one component of a difference vector
  localparam int PW     = 46;            // one component of a cross product
  localparam int SPLIT  = 23;            // low part of a split cross product
  localparam int MW     = 24;            // multiplier operand width
  localparam int ACC_W  = 72;            // accumulator and dot-product width
  localparam int DW     = 32;            // distance width, unsigned Q16.16
  localparam int DFRAC  = 16;
  localparam int IN_CW  = 9 * CW;        // packed vertex coordinates
  localparam int IN_DW  = 192;
  localparam logic [DW-1:0] DIST_MAX = '1;

  localparam int TRI_STEPS  = 36;
  localparam int SLAB_STEPS = 6;

  // Datapath operations.
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_CAP      = 4'd1;
  localparam logic [3:0] OP_SETUP    = 4'd2;
  localparam logic [3:0] OP_MAC      = 4'd3;
  localparam logic [3:0] OP_SLAB_END = 4'd4;
  localparam logic [3:0] OP_BOX_WR   = 4'd5;
  localparam logic [3:0] OP_NORM     = 4'd6;
  localparam logic [3:0] OP_DIV_TRI  = 4'd7;
  localparam logic [3:0] OP_TRI_UPD  = 4'd8;
  localparam logic [3:0] OP_EMIT     = 4'd9;

  // Multiplier operand codes.
  localparam logic [4:0] OPD_D0   = 5'd0;
  localparam logic [4:0] OPD_D1   = 5'd1;
  localparam logic [4:0] OPD_D2   = 5'd2;
  localparam logic [4:0] OPD_E10  = 5'd3;
  localparam logic [4:0] OPD_E11  = 5'd4;
  localparam logic [4:0] OPD_E12  = 5'd5;
  localparam logic [4:0] OPD_E20  = 5'd6;
  localparam logic [4:0] OPD_E21  = 5'd7;
  localparam logic [4:0] OPD_E22  = 5'd8;
  localparam logic [4:0] OPD_S0   = 5'd9;
  localparam logic [4:0] OPD_S1   = 5'd10;
  localparam logic [4:0] OPD_S2   = 5'd11;
  localparam logic [4:0] OPD_PL0  = 5'd12;
  localparam logic [4:0] OPD_PL1  = 5'd13;
  localparam logic [4:0] OPD_PL2  = 5'd14;
  localparam logic [4:0] OPD_PH0  = 5'd15;
  localparam logic [4:0] OPD_PH1  = 5'd16;
  localparam logic [4:0] OPD_PH2  = 5'd17;
  localparam logic [4:0] OPD_QL0  = 5'd18;
  localparam logic [4:0] OPD_QL1  = 5'd19;
  localparam logic [4:0] OPD_QL2  = 5'd20;
  localparam logic [4:0] OPD_QH0  = 5'd21;
  localparam logic [4:0] OPD_QH1  = 5'd22;
  localparam logic [4:0] OPD_QH2  = 5'd23;
  localparam logic [4:0] OPD_N1   = 5'd24;
  localparam logic [4:0] OPD_N2   = 5'd25;
  localparam logic [4:0] OPD_DEN  = 5'd26;
  localparam logic [4:0] OPD_MN   = 5'd27;
  localparam logic [4:0] OPD_MD   = 5'd28;
  localparam logic [4:0] OPD_XN   = 5'd29;
  localparam logic [4:0] OPD_XD   = 5'd30;

  // Accumulator destinations.
  localparam logic [3:0] DST_NONE = 4'd0;
  localparam logic [3:0] DST_P0   = 4'd1;
  localparam logic [3:0] DST_P1   = 4'd2;
  localparam logic [3:0] DST_P2   = 4'd3;
  localparam logic [3:0] DST_Q0   = 4'd4;
  localparam logic [3:0] DST_Q1   = 4'd5;
  localparam logic [3:0] DST_Q2   = 4'd6;
  localparam logic [3:0] DST_DET  = 4'd7;
  localparam logic [3:0] DST_UN   = 4'd8;
  localparam logic [3:0] DST_VN   = 4'd9;
  localparam logic [3:0] DST_TN   = 4'd10;
  localparam logic [3:0] DST_UMN  = 4'd11;
  localparam logic [3:0] DST_UXN  = 4'd12;
  localparam logic [3:0] DST_CHK  = 4'd13;

  typedef struct packed {
    logic [4:0] a;
    logic [4:0] b;
    logic       neg;
    logic       clr;
    logic       sh;
    logic [3:0] dst;
  } uop_t;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] axis;
    uop_t       uop;
  } cmd_t;

  typedef struct packed {
    logic query_open;
    logic par;
    logic box_hit;
    logic box_need_div;
    logic item_mode;
    logic item_idxv;
    logic item_last;
    logic det_zero;
    logic tri_reject;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic uop_t mk(input logic [4:0] a, input logic [4:0] b, input logic neg,
                              input logic clr, input logic sh, input logic [3:0] dst);
    uop_t u;
    u.a   = a;
    u.b   = b;
    u.neg = neg;
    u.clr = clr;
    u.sh  = sh;
    u.dst = dst;
    return u;
  endfunction

  // Triangle program: p = d x e2, q = s x e1, then det, u, v and t numerators.
  function automatic uop_t tri_uop(input logic [5:0] i);
    uop_t u;
    unique case (i)
      6'd0:  u = mk(OPD_D1,  OPD_E22, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd1:  u = mk(OPD_D2,  OPD_E21, 1'b1, 1'b0, 1'b0, DST_P0);
      6'd2:  u = mk(OPD_D2,  OPD_E20, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd3:  u = mk(OPD_D0,  OPD_E22, 1'b1, 1'b0, 1'b0, DST_P1);
      6'd4:  u = mk(OPD_D0,  OPD_E21, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd5:  u = mk(OPD_D1,  OPD_E20, 1'b1, 1'b0, 1'b0, DST_P2);
      6'd6:  u = mk(OPD_S1,  OPD_E12, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd7:  u = mk(OPD_S2,  OPD_E11, 1'b1, 1'b0, 1'b0, DST_Q0);
      6'd8:  u = mk(OPD_S2,  OPD_E10, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd9:  u = mk(OPD_S0,  OPD_E12, 1'b1, 1'b0, 1'b0, DST_Q1);
      6'd10: u = mk(OPD_S0,  OPD_E11, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd11: u = mk(OPD_S1,  OPD_E10, 1'b1, 1'b0, 1'b0, DST_Q2);
      6'd12: u = mk(OPD_E10, OPD_PL0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd13: u = mk(OPD_E10, OPD_PH0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd14: u = mk(OPD_E11, OPD_PL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd15: u = mk(OPD_E11, OPD_PH1, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd16: u = mk(OPD_E12, OPD_PL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd17: u = mk(OPD_E12, OPD_PH2, 1'b0, 1'b0, 1'b1, DST_DET);
      6'd18: u = mk(OPD_S0,  OPD_PL0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd19: u = mk(OPD_S0,  OPD_PH0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd20: u = mk(OPD_S1,  OPD_PL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd21: u = mk(OPD_S1,  OPD_PH1, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd22: u = mk(OPD_S2,  OPD_PL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd23: u = mk(OPD_S2,  OPD_PH2, 1'b0, 1'b0, 1'b1, DST_UN);
      6'd24: u = mk(OPD_D0,  OPD_QL0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd25: u = mk(OPD_D0,  OPD_QH0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd26: u = mk(OPD_D1,  OPD_QL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd27: u = mk(OPD_D1,  OPD_QH1, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd28: u = mk(OPD_D2,  OPD_QL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd29: u = mk(OPD_D2,  OPD_QH2, 1'b0, 1'b0, 1'b1, DST_VN);
      6'd30: u = mk(OPD_E20, OPD_QL0, 1'b0, 1'b1, 1'b0, DST_NONE);
      6'd31: u = mk(OPD_E20, OPD_QH0, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd32: u = mk(OPD_E21, OPD_QL1, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd33: u = mk(OPD_E21, OPD_QH1, 1'b0, 1'b0, 1'b1, DST_NONE);
      6'd34: u = mk(OPD_E22, OPD_QL2, 1'b0, 1'b0, 1'b0, DST_NONE);
      6'd35: u = mk(OPD_E22, OPD_QH2, 1'b0, 1'b0, 1'b1, DST_TN);
      default: u = mk(OPD_D0, OPD_D0, 1'b0, 1'b1, 1'b0, DST_NONE);
    endcase
    return u;
  endfunction

  // Slab program for one axis: update entry, update exit, check for a miss.
  function automatic uop_t slab_uop(input logic [2:0] i);
    uop_t u;
    unique case (i)
      3'd0: u = mk(OPD_N1, OPD_MD,  1'b0, 1'b1, 1'b0, DST_NONE);
      3'd1: u = mk(OPD_MN, OPD_DEN, 1'b1, 1'b0, 1'b0, DST_UMN);
      3'd2: u = mk(OPD_N2, OPD_XD,  1'b0, 1'b1, 1'b0, DST_NONE);
      3'd3: u = mk(OPD_XN, OPD_DEN, 1'b1, 1'b0, 1'b0, DST_UXN);
      3'd4: u = mk(OPD_MN, OPD_XD,  1'b0, 1'b1, 1'b0, DST_NONE);
      3'd5: u = mk(OPD_XN, OPD_MD,  1'b1, 1'b0, 1'b0, DST_CHK);
      default: u = mk(OPD_D0, OPD_D0, 1'b0, 1'b1, 1'b0, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

FILE: rtl/core/rmnh_div.sv
`timescale 1ns / 1ps
// Restoring divider: floor(num * 2^16 / den), one quotient bit a cycle,
// saturating when the quotient does not fit the distance width.
module rmnh_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rmnh_pkg::ACC_W-1:0]    num,
  input  logic [rmnh_pkg::ACC_W-1:0]    den,
  output logic                          done,
  output logic [rmnh_pkg::DW-1:0]       quot
);

  localparam int AW = rmnh_pkg::ACC_W;
  localparam int QW = rmnh_pkg::DW;
  localparam int FB = rmnh_pkg::DFRAC;

  logic          busy_r;
  logic          done_r;
  logic [5:0]    cnt_r;
  logic          sat_r;
  logic [AW-1:0] rem_r;
  logic [AW-1:0] den_r;
  logic [QW-1:0] sh_r;
  logic [QW-1:0] q_r;

  logic [AW:0]      trial;
  logic [AW:0]      diff;
  logic             ge;
  logic             sat_c;

  always_comb begin
    trial = {rem_r, sh_r[QW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
    sat_c = {{FB{1'b0}}, num} >= {den, {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (sat_c) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 6'(QW);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat_r <= sat_c;
      den_r <= den;
      rem_r <= {{FB{1'b0}}, num[AW-1:FB]};
      sh_r  <= {num[FB-1:0], {(QW-FB){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[AW-1:0] : trial[AW-1:0];
      sh_r  <= {sh_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = sat_r ? rmnh_pkg::DIST_MAX : q_r;

endmodule

FILE: rtl/core/rmnh_dp.sv
`timescale 1ns / 1ps
// Datapath: item capture, slab setup, one shared multiply-accumulate unit,
// triangle checks, the nearest-hit state and the output register.
module rmnh_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rmnh_pkg::REG_W-1:0]   ray_origin,
  input  logic [rmnh_pkg::REG_W-1:0]   ray_direction,
  input  logic [rmnh_pkg::REG_W-1:0]   box_min,
  input  logic [rmnh_pkg::REG_W-1:0]   box_max,
  input  logic [rmnh_pkg::IN_CW-1:0]   item_coords,
  input  logic                         item_mode,
  input  logic                         item_idxv,
  input  logic                         item_last,
  input  rmnh_pkg::cmd_t               cmd,
  output rmnh_pkg::sts_t               sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic                         out_exact,
  output logic [rmnh_pkg::DW-1:0]      out_dist
);

  localparam int CW = rmnh_pkg::CW;
  localparam int VW = rmnh_pkg::VW;
  localparam int PW = rmnh_pkg::PW;
  localparam int SP = rmnh_pkg::SPLIT;
  localparam int MW = rmnh_pkg::MW;
  localparam int AW = rmnh_pkg::ACC_W;
  localparam int DW = rmnh_pkg::DW;

  // Captured item.
  logic                 mode_r, idxv_r, last_r;
  logic signed [VW-1:0] e1_r [0:2];
  logic signed [VW-1:0] e2_r [0:2];
  logic signed [VW-1:0] s_r  [0:2];
  logic signed [PW-1:0] p_r  [0:2];
  logic signed [PW-1:0] q_r  [0:2];

  logic signed [AW-1:0] acc_r, det_r, un_r, vn_r, tn_r;
  logic signed [VW-1:0] n1_r, n2_r, den_r, mn_r, md_r, xn_r, xd_r;
  logic                 have_r, miss_r;

  logic                 qopen_r, box_hit_r, found_r;
  logic [DW-1:0]        box_dist_r, near_r;
  logic                 out_valid_r, out_hit_r, out_exact_r;
  logic [DW-1:0]        out_dist_r;

  // Unpacked configuration.
  logic signed [VW-1:0] oc [0:2];
  logic signed [VW-1:0] dc [0:2];
  logic signed [VW-1:0] lc [0:2];
  logic signed [VW-1:0] hc [0:2];
  logic signed [VW-1:0] va [0:2];
  logic signed [VW-1:0] vb [0:2];
  logic signed [VW-1:0] vc [0:2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oc[k] = VW'($signed(ray_origin[k*CW +: CW]));
      dc[k] = VW'($signed(ray_direction[k*CW +: CW]));
      lc[k] = VW'($signed(box_min[k*CW +: CW]));
      hc[k] = VW'($signed(box_max[k*CW +: CW]));
      va[k] = VW'($signed(item_coords[k*CW +: CW]));
      vb[k] = VW'($signed(item_coords[(3+k)*CW +: CW]));
      vc[k] = VW'($signed(item_coords[(6+k)*CW +: CW]));
    end
  end

  // Slab setup for the selected axis.
  logic signed [VW-1:0] so, sd, sl, shi, a1, a2, dn;
  logic                 par_c, outside_c;

  always_comb begin
    so        = oc[cmd.axis];
    sd        = dc[cmd.axis];
    sl        = lc[cmd.axis];
    shi       = hc[cmd.axis];
    par_c     = sd == '0;
    outside_c = (so < sl) || (so > shi);
    if (sd > 0) begin
      a1 = sl - so;
      a2 = shi - so;
      dn = sd;
    end else begin
      a1 = so - sl;
      a2 = so - shi;
      dn = -sd;
    end
  end

  // Shared multiply-accumulate unit.
  logic signed [MW-1:0]   opv [0:31];
  logic signed [MW-1:0]   opa, opb;
  logic signed [2*MW-1:0] prod;
  logic signed [AW-1:0]   prod_x, term, acc_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opv[rmnh_pkg::OPD_D0 + k]  = MW'(dc[k]);
      opv[rmnh_pkg::OPD_E10 + k] = MW'(e1_r[k]);
      opv[rmnh_pkg::OPD_E20 + k] = MW'(e2_r[k]);
      opv[rmnh_pkg::OPD_S0 + k]  = MW'(s_r[k]);
      opv[rmnh_pkg::OPD_PL0 + k] = {{(MW-SP){1'b0}}, p_r[k][SP-1:0]};
      opv[rmnh_pkg::OPD_PH0 + k] = {p_r[k][PW-1], p_r[k][PW-1:SP]};
      opv[rmnh_pkg::OPD_QL0 + k] = {{(MW-SP){1'b0}}, q_r[k][SP-1:0]};
      opv[rmnh_pkg::OPD_QH0 + k] = {q_r[k][PW-1], q_r[k][PW-1:SP]};
    end
    opv[rmnh_pkg::OPD_N1]  = MW'(n1_r);
    opv[rmnh_pkg::OPD_N2]  = MW'(n2_r);
    opv[rmnh_pkg::OPD_DEN] = MW'(den_r);
    opv[rmnh_pkg::OPD_MN]  = MW'(mn_r);
    opv[rmnh_pkg::OPD_MD]  = MW'(md_r);
    opv[rmnh_pkg::OPD_XN]  = MW'(xn_r);
    opv[rmnh_pkg::OPD_XD]  = MW'(xd_r);
    opv[31]                = '0;
    opa     = opv[cmd.uop.a];
    opb     = opv[cmd.uop.b];
    prod    = opa * opb;
    prod_x  = AW'(prod);
    if (cmd.uop.sh) begin
      prod_x = prod_x <<< SP;
    end
    term    = cmd.uop.neg ? -prod_x : prod_x;
    acc_nxt = (cmd.uop.clr ? '0 : acc_r) + term;
  end

  // Box result and triangle acceptance.
  logic                 box_hit_c, need_div_c, reject_c;
  logic signed [AW:0]   uv_sum;

  always_comb begin
    box_hit_c  = !miss_r && !(have_r && xn_r < 0);
    need_div_c = box_hit_c && have_r && (mn_r > 0);
    uv_sum     = {un_r[AW-1], un_r} + {vn_r[AW-1], vn_r};
    reject_c   = (un_r < 0) || (un_r > det_r) || (vn_r < 0) ||
                 (uv_sum > {det_r[AW-1], det_r}) || (tn_r < 0);
  end

  // Divider shared between the box entry distance and the triangle distance.
  logic          div_start, div_done;
  logic [AW-1:0] div_num, div_den;
  logic [DW-1:0] div_q;

  assign div_start = ((cmd.op == rmnh_pkg::OP_SLAB_END) && need_div_c) ||
                     (cmd.op == rmnh_pkg::OP_DIV_TRI);
  assign div_num   = (cmd.op == rmnh_pkg::OP_DIV_TRI) ? tn_r : AW'(unsigned'(mn_r));
  assign div_den   = (cmd.op == rmnh_pkg::OP_DIV_TRI) ? det_r : AW'(unsigned'(md_r));

  rmnh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Query state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qopen_r     <= 1'b0;
      box_hit_r   <= 1'b0;
      box_dist_r  <= '0;
      found_r     <= 1'b0;
      near_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        rmnh_pkg::OP_CAP: begin
          if (!qopen_r) begin
            qopen_r <= 1'b1;
            found_r <= 1'b0;
            near_r  <= '1;
          end
        end
        rmnh_pkg::OP_SLAB_END: begin
          box_hit_r  <= box_hit_c;
          box_dist_r <= '0;
        end
        rmnh_pkg::OP_BOX_WR: box_dist_r <= div_q;
        rmnh_pkg::OP_TRI_UPD: begin
          if (!found_r || div_q < near_r) begin
            found_r <= 1'b1;
            near_r  <= div_q;
          end
        end
        rmnh_pkg::OP_EMIT: begin
          qopen_r     <= 1'b0;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rmnh_pkg::OP_CAP: begin
        mode_r <= item_mode;
        idxv_r <= item_idxv;
        last_r <= item_last;
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= vb[k] - va[k];
          e2_r[k] <= vc[k] - va[k];
          s_r[k]  <= oc[k] - va[k];
        end
        if (!qopen_r) begin
          have_r <= 1'b0;
          miss_r <= 1'b0;
          mn_r   <= '0;
          md_r   <= VW'(1);
          xn_r   <= '0;
          xd_r   <= VW'(1);
        end
      end
      rmnh_pkg::OP_SETUP: begin
        if (par_c && outside_c) begin
          miss_r <= 1'b1;
        end
        n1_r  <= (a1 > a2) ? a2 : a1;
        n2_r  <= (a1 > a2) ? a1 : a2;
        den_r <= dn;
      end
      rmnh_pkg::OP_MAC: begin
        acc_r <= acc_nxt;
        unique case (cmd.uop.dst)
          rmnh_pkg::DST_P0:  p_r[0] <= acc_nxt[PW-1:0];
          rmnh_pkg::DST_P1:  p_r[1] <= acc_nxt[PW-1:0];
          rmnh_pkg::DST_P2:  p_r[2] <= acc_nxt[PW-1:0];
          rmnh_pkg::DST_Q0:  q_r[0] <= acc_nxt[PW-1:0];
          rmnh_pkg::DST_Q1:  q_r[1] <= acc_nxt[PW-1:0];
          rmnh_pkg::DST_Q2:  q_r[2] <= acc_nxt[PW-1:0];
          rmnh_pkg::DST_DET: det_r  <= acc_nxt;
          rmnh_pkg::DST_UN:  un_r   <= acc_nxt;
          rmnh_pkg::DST_VN:  vn_r   <= acc_nxt;
          rmnh_pkg::DST_TN:  tn_r   <= acc_nxt;
          rmnh_pkg::DST_UMN: begin
            if (!have_r || acc_nxt > 0) begin
              mn_r <= n1_r;
              md_r <= den_r;
            end
          end
          rmnh_pkg::DST_UXN: begin
            if (!have_r || acc_nxt < 0) begin
              xn_r <= n2_r;
              xd_r <= den_r;
            end
            have_r <= 1'b1;
          end
          rmnh_pkg::DST_CHK: begin
            if (acc_nxt > 0) begin
              miss_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      rmnh_pkg::OP_NORM: begin
        // A negative determinant flips the sign of every numerator.
        if (det_r < 0) begin
          det_r <= -det_r;
          un_r  <= -un_r;
          vn_r  <= -vn_r;
          tn_r  <= -tn_r;
        end
      end
      rmnh_pkg::OP_EMIT: begin
        if (mode_r) begin
          out_hit_r   <= box_hit_r;
          out_exact_r <= 1'b0;
          out_dist_r  <= box_hit_r ? box_dist_r : '0;
        end else begin
          out_hit_r   <= box_hit_r && found_r;
          out_exact_r <= box_hit_r && found_r;
          out_dist_r  <= (box_hit_r && found_r) ? near_r : '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.query_open   = qopen_r;
    sts.par          = par_c;
    sts.box_hit      = box_hit_r;
    sts.box_need_div = need_div_c;
    sts.item_mode    = mode_r;
    sts.item_idxv    = idxv_r;
    sts.item_last    = last_r;
    sts.det_zero     = det_r == '0;
    sts.tri_reject   = reject_c;
    sts.div_done     = div_done;
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_exact = out_exact_r;
  assign out_dist  = out_dist_r;

endmodule

FILE: rtl/core/rmnh_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: walks the slab program per axis and the triangle program, and
// waits on the divider and the output register.
module rmnh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  rmnh_pkg::sts_t sts,
  output rmnh_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_SLAB_SETUP = 4'd1;
  localparam logic [3:0] ST_SLAB_MAC   = 4'd2;
  localparam logic [3:0] ST_SLAB_END   = 4'd3;
  localparam logic [3:0] ST_BOX_DIV    = 4'd4;
  localparam logic [3:0] ST_DISPATCH   = 4'd5;
  localparam logic [3:0] ST_TRI_MAC    = 4'd6;
  localparam logic [3:0] ST_TRI_NORM   = 4'd7;
  localparam logic [3:0] ST_TRI_CHECK  = 4'd8;
  localparam logic [3:0] ST_TRI_DIV    = 4'd9;
  localparam logic [3:0] ST_EMIT       = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [5:0] step_r, step_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [3:0] fin_state;

  assign fin_state = sts.item_last ? ST_EMIT : ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    in_tready = 1'b0;
    cmd.op    = rmnh_pkg::OP_NOP;
    cmd.axis  = axis_r;
    cmd.uop   = (state_r == ST_SLAB_MAC) ? rmnh_pkg::slab_uop(step_r[2:0])
                                         : rmnh_pkg::tri_uop(step_r);
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = rmnh_pkg::OP_CAP;
          axis_nxt  = '0;
          state_nxt = sts.query_open ? ST_DISPATCH : ST_SLAB_SETUP;
        end
      end
      ST_SLAB_SETUP: begin
        cmd.op = rmnh_pkg::OP_SETUP;
        if (sts.par) begin
          if (axis_r == 2'd2) begin
            state_nxt = ST_SLAB_END;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          step_nxt  = '0;
          state_nxt = ST_SLAB_MAC;
        end
      end
      ST_SLAB_MAC: begin
        cmd.op = rmnh_pkg::OP_MAC;
        if (step_r == 6'(rmnh_pkg::SLAB_STEPS - 1)) begin
          if (axis_r == 2'd2) begin
            state_nxt = ST_SLAB_END;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_SLAB_SETUP;
          end
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_SLAB_END: begin
        cmd.op    = rmnh_pkg::OP_SLAB_END;
        state_nxt = sts.box_need_div ? ST_BOX_DIV : ST_DISPATCH;
      end
      ST_BOX_DIV: begin
        if (sts.div_done) begin
          cmd.op    = rmnh_pkg::OP_BOX_WR;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.item_mode) begin
          state_nxt = ST_EMIT;
        end else if (sts.box_hit && sts.item_idxv) begin
          step_nxt  = '0;
          state_nxt = ST_TRI_MAC;
        end else begin
          state_nxt = fin_state;
        end
      end
      ST_TRI_MAC: begin
        cmd.op = rmnh_pkg::OP_MAC;
        if (step_r == 6'(rmnh_pkg::TRI_STEPS - 1)) begin
          state_nxt = ST_TRI_NORM;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_TRI_NORM: begin
        if (sts.det_zero) begin
          state_nxt = fin_state;
        end else begin
          cmd.op    = rmnh_pkg::OP_NORM;
          state_nxt = ST_TRI_CHECK;
        end
      end
      ST_TRI_CHECK: begin
        if (sts.tri_reject) begin
          state_nxt = fin_state;
        end else begin
          cmd.op    = rmnh_pkg::OP_DIV_TRI;
          state_nxt = ST_TRI_DIV;
        end
      end
      ST_TRI_DIV: begin
        if (sts.div_done) begin
          cmd.op    = rmnh_pkg::OP_TRI_UPD;
          state_nxt = fin_state;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.op    = rmnh_pkg::OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
    end
  end

  a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again right after an item");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_BOX_DIV || state_r == ST_TRI_DIV))
    else $error("divider finished while nobody waited for it");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == rmnh_pkg::OP_EMIT |-> sts.out_free)
    else $error("result written over an untaken result");

endmodule

FILE: rtl/core/ray_mesh_nearest_hit.sv
`timescale 1ns / 1ps
// Nearest hit of one ray against a bounding box and a stream of triangles.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 ray origin, 1 ray direction, 2 box min, 3 box max), each x,y,z packed
// as signed 21-bit fields, x lowest. Write only while the block is idle.
// Input channel: one item per triangle. The first item of a query runs the
// slab test, and a restoring division for the entry distance when needed.
// A triangle item runs 36 multiply-accumulate steps on the single shared
// 24x24 multiplier, a normalisation step, a check and a restoring division;
// a skipped or rejected triangle ends early. One item is in work at a time.
// Output channel: one item on a last or box-only input item, held in an
// output register. A stalled receiver holds that item; the block still takes
// and works the next input item, and waits only when it has a new result to
// place and the register is still full.
// Reset (synchronous, active low) clears the configuration and control registers, closes any query and
// empties the output register.
module ray_mesh_nearest_hit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [1:0]                    cfg_index,
  input  logic [rmnh_pkg::REG_W-1:0]    cfg_wdata,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // corner_a_x, corner_a_y, corner_a_z, corner_b_x .. corner_c_z, zero pad
  input  logic [rmnh_pkg::IN_DW-1:0]    in_tdata,
  // mode, indices_valid
  input  logic [1:0]                    in_tuser,
  input  logic                          in_tlast,
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // distance
  output logic [rmnh_pkg::DW-1:0]       out_tdata,
  // hit, exact
  output logic [1:0]                    out_tuser
);

  localparam logic [1:0] REG_ORIGIN = 2'd0;
  localparam logic [1:0] REG_DIR    = 2'd1;
  localparam logic [1:0] REG_BMIN   = 2'd2;
  localparam logic [1:0] REG_BMAX   = 2'd3;

  logic [rmnh_pkg::REG_W-1:0] origin_r, dir_r, bmin_r, bmax_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      dir_r    <= '0;
      bmin_r   <= '0;
      bmax_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ORIGIN: origin_r <= cfg_wdata;
        REG_DIR:    dir_r    <= cfg_wdata;
        REG_BMIN:   bmin_r   <= cfg_wdata;
        REG_BMAX:   bmax_r   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  rmnh_pkg::cmd_t cmd;
  rmnh_pkg::sts_t sts;
  logic           hit, exact;

  rmnh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rmnh_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ray_origin    (origin_r),
    .ray_direction (dir_r),
    .box_min       (bmin_r),
    .box_max       (bmax_r),
    .item_coords   (in_tdata[rmnh_pkg::IN_CW-1:0]),
    .item_mode     (in_tuser[0]),
    .item_idxv     (in_tuser[1]),
    .item_last     (in_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_hit       (hit),
    .out_exact     (exact),
    .out_dist      (out_tdata)
  );

  assign out_tuser = {exact, hit};

endmodule
